// ----- rtl/circle_collision_test_top_assert.svh -----
// assertion macros for the circle collision test block
// used by the port checker; expects clk and rst_n in scope
`ifndef CIRCLE_COLLISION_TEST_TOP_ASSERT_SVH
`define CIRCLE_COLLISION_TEST_TOP_ASSERT_SVH

// plain property, checked out of reset
`define CCT_CHECK(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    prop) else $error("circle collision port check failed");

// implication form
`define CCT_IMPLY(lbl, ante, cons) `CCT_CHECK(lbl, (ante) |-> (cons))

`endif

// ----- rtl/cct_pkg.sv -----
// shared types and constants for the circle collision test block
// no dependencies
package cct_pkg;

    localparam logic ACT_CIRCLE  = 1'b0;
    localparam logic ACT_SEGMENT = 1'b1;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 15;
    localparam int NUM_W      = 46;
    localparam int CCT_LATENCY = 3 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    localparam logic [DIV_STEPS-1:0] NORM_ONE = DIV_STEPS'(16384);

    typedef struct packed {
        logic               action;
        logic signed [23:0] centre_a_x;
        logic signed [23:0] centre_a_y;
        logic [22:0]        radius_a;
        logic signed [23:0] origin_b_x;
        logic signed [23:0] origin_b_y;
        logic [22:0]        radius_b;
        logic signed [23:0] seg_start_x;
        logic signed [23:0] seg_start_y;
        logic signed [23:0] seg_end_x;
        logic signed [23:0] seg_end_y;
    } cct_in_t;

    typedef struct packed {
        logic               hit;
        logic [23:0]        depth;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
    } cct_out_t;

endpackage

// ----- rtl/cct_sqrt.sv -----
// pipelined integer square root, one root bit per stage
// depends on cct_pkg
module cct_sqrt (
    input  logic                          clk,
    input  logic [2*cct_pkg::SQRT_STEPS-1:0] radicand,
    output logic [cct_pkg::SQRT_STEPS-1:0]   root
);
    import cct_pkg::*;

    localparam int RW = SQRT_STEPS;
    localparam int DW = 2 * SQRT_STEPS;

    logic [RW+1:0] rem_reg  [SQRT_STEPS];
    logic [RW+1:0] rem_next [SQRT_STEPS];
    logic [RW-1:0] root_reg  [SQRT_STEPS];
    logic [RW-1:0] root_next [SQRT_STEPS];
    logic [DW-1:0] rad_reg  [SQRT_STEPS];
    logic [DW-1:0] rad_next [SQRT_STEPS];

    always_comb
    begin
        logic [RW+1:0] pr_rem;
        logic [RW-1:0] pr_root;
        logic [DW-1:0] pr_rad;
        logic [RW+1:0] acc;
        logic [RW+1:0] trial;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            if (k == 0)
            begin
                pr_rem  = '0;
                pr_root = '0;
                pr_rad  = radicand;
            end
            else
            begin
                pr_rem  = rem_reg[k-1];
                pr_root = root_reg[k-1];
                pr_rad  = rad_reg[k-1];
            end
            // bring down the next two radicand bits, try 4r+1
            acc   = {pr_rem[RW-1:0], pr_rad[DW-1:DW-2]};
            trial = {pr_root, 2'b01};
            if (acc >= trial)
            begin
                rem_next[k]  = acc - trial;
                root_next[k] = {pr_root[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = acc;
                root_next[k] = {pr_root[RW-2:0], 1'b0};
            end
            rad_next[k] = {pr_rad[DW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
            rad_reg[k]  <= rad_next[k];
        end
    end

    assign root = root_reg[SQRT_STEPS-1];

endmodule

// ----- rtl/cct_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// quotient must fit DIV_STEPS bits; depends on cct_pkg
module cct_div (
    input  logic                           clk,
    input  logic [cct_pkg::NUM_W-1:0]      num,
    input  logic [cct_pkg::SQRT_STEPS-1:0] den,
    output logic [cct_pkg::DIV_STEPS-1:0]  quo
);
    import cct_pkg::*;

    localparam int QW = DIV_STEPS;
    localparam int DN = SQRT_STEPS;

    logic [DN-1:0] rem_reg  [DIV_STEPS];
    logic [DN-1:0] rem_next [DIV_STEPS];
    logic [QW-1:0] low_reg  [DIV_STEPS];
    logic [QW-1:0] low_next [DIV_STEPS];
    logic [QW-1:0] quo_reg  [DIV_STEPS];
    logic [QW-1:0] quo_next [DIV_STEPS];
    logic [DN-1:0] den_reg  [DIV_STEPS];

    always_comb
    begin
        logic [DN-1:0] pr_rem;
        logic [QW-1:0] pr_low;
        logic [QW-1:0] pr_quo;
        logic [DN-1:0] pr_den;
        logic [DN:0]   acc;
        logic [DN:0]   dif;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (k == 0)
            begin
                pr_rem = DN'(num[NUM_W-1:QW]);
                pr_low = num[QW-1:0];
                pr_quo = '0;
                pr_den = den;
            end
            else
            begin
                pr_rem = rem_reg[k-1];
                pr_low = low_reg[k-1];
                pr_quo = quo_reg[k-1];
                pr_den = den_reg[k-1];
            end
            acc = {pr_rem, pr_low[QW-1]};
            dif = acc - {1'b0, pr_den};
            if (acc >= {1'b0, pr_den})
            begin
                rem_next[k] = dif[DN-1:0];
                quo_next[k] = {pr_quo[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = acc[DN-1:0];
                quo_next[k] = {pr_quo[QW-2:0], 1'b0};
            end
            low_next[k] = {pr_low[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            rem_reg[k] <= rem_next[k];
            low_reg[k] <= low_next[k];
            quo_reg[k] <= quo_next[k];
        end
        den_reg[0] <= den;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            den_reg[k] <= den_reg[k-1];
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

// ----- rtl/circle_collision_test_top.sv -----
// circle/circle and circle/segment collision test, fully pipelined
// depends on cct_pkg, cct_sqrt, cct_div
//
// usage:
//   start/request: one test item per cycle; busy stays low, so an item is
//   taken at every edge where start is high
//   done/result: one result per item, shown for one cycle, in item order
//   the pipe holds 3 front stages, then the 32-stage square root (one root
//   bit per stage), one stage between the two units, the 15-stage normal
//   divider (one quotient bit per stage) and the output stage; throughput
//   one item per clock
//   the circle hit and the segment test run beside the square root stages
//   reset clears the valid line only; no item is in flight afterwards and no
//   clearing pass is needed
//   the receiver cannot stall; there is no backpressure anywhere
module circle_collision_test_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cct_pkg::cct_in_t  request,
    output logic              done,
    output cct_pkg::cct_out_t result
);
    import cct_pkg::*;

    localparam int SIDE_DLY = SQRT_STEPS - 4;

    typedef struct packed {
        logic               act;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [23:0]        sum;
        logic signed [24:0] abx;
        logic signed [24:0] aby;
        logic signed [25:0] acx;
        logic signed [25:0] acy;
        logic signed [25:0] ecx;
        logic signed [25:0] ecy;
        logic [22:0]        ra;
    } p1_t;

    typedef struct packed {
        logic        act;
        logic        hit;
        logic        nz;
        logic [23:0] sum;
        logic        neg_x;
        logic        neg_y;
        logic [23:0] mag_x;
        logic [23:0] mag_y;
    } side_t;

    typedef struct packed {
        side_t              side;
        logic [47:0]        dx2;
        logic [47:0]        dy2;
        logic [47:0]        sum2;
        logic signed [50:0] dot_x;
        logic signed [50:0] dot_y;
        logic [47:0]        abx2;
        logic [47:0]        aby2;
        logic signed [50:0] cr_a;
        logic signed [50:0] cr_b;
        logic [49:0]        ac2x;
        logic [49:0]        ac2y;
        logic [49:0]        ec2x;
        logic [49:0]        ec2y;
        logic [45:0]        r2;
    } p2_t;

    typedef struct packed {
        side_t              side;
        logic [49:0]        s;
        logic [47:0]        sum2;
        logic signed [51:0] dot;
        logic [49:0]        l2;
        logic signed [51:0] cr;
        logic [50:0]        da;
        logic [50:0]        de;
        logic [45:0]        r2;
    } p3_t;

    typedef struct packed {
        side_t       side;
        logic [50:0] crm;
        logic        lo;
        logic        hi;
        logic        hit_a;
        logic        hit_e;
        logic [45:0] r2;
        logic [49:0] l2;
    } p4_t;

    typedef struct packed {
        side_t       side;
        logic        lo;
        logic        hi;
        logic        hit_a;
        logic        hit_e;
        logic [49:0] phh;
        logic [50:0] phl;
        logic [51:0] pll;
        logic [46:0] q11;
        logic [48:0] q10;
        logic [46:0] q01;
        logic [48:0] q00;
    } p5_t;

    typedef struct packed {
        side_t        side;
        logic         lo;
        logic         hi;
        logic         hit_a;
        logic         hit_e;
        logic [101:0] cr_sq;
        logic [101:0] rl;
    } p6_t;

    typedef struct packed {
        logic        hit;
        logic        nrm_en;
        logic        neg_x;
        logic        neg_y;
        logic [23:0] depth;
    } tail_t;

    typedef struct packed {
        tail_t            tail;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [SQRT_STEPS-1:0] den;
    } pn_t;

    logic [CCT_LATENCY-1:0] vld_reg, vld_next;
    p1_t   p1_reg, p1_next;
    p2_t   p2_reg, p2_next;
    p3_t   p3_reg, p3_next;
    p4_t   p4_reg, p4_next;
    p5_t   p5_reg, p5_next;
    p6_t   p6_reg, p6_next;
    side_t p7_reg, p7_next;
    side_t side_reg [SIDE_DLY];
    pn_t   pn_reg, pn_next;
    tail_t tail_reg [DIV_STEPS];
    cct_out_t res_reg, res_next;

    logic [SQRT_STEPS-1:0] root;
    logic [DIV_STEPS-1:0]  quo_x, quo_y;

    assign busy = 1'b0;

    // front stage: coordinate differences and the radius sum
    always_comb
    begin
        p1_next.act = request.action;
        p1_next.dx  = {request.origin_b_x[23], request.origin_b_x}
                    - {request.centre_a_x[23], request.centre_a_x};
        p1_next.dy  = {request.origin_b_y[23], request.origin_b_y}
                    - {request.centre_a_y[23], request.centre_a_y};
        p1_next.sum = {1'b0, request.radius_a} + {1'b0, request.radius_b};
        p1_next.abx = {request.seg_end_x[23], request.seg_end_x}
                    - {request.seg_start_x[23], request.seg_start_x};
        p1_next.aby = {request.seg_end_y[23], request.seg_end_y}
                    - {request.seg_start_y[23], request.seg_start_y};
        p1_next.acx = 26'(request.centre_a_x) - 26'(request.origin_b_x)
                    - 26'(request.seg_start_x);
        p1_next.acy = 26'(request.centre_a_y) - 26'(request.origin_b_y)
                    - 26'(request.seg_start_y);
        p1_next.ecx = 26'(request.centre_a_x) - 26'(request.origin_b_x)
                    - 26'(request.seg_end_x);
        p1_next.ecy = 26'(request.centre_a_y) - 26'(request.origin_b_y)
                    - 26'(request.seg_end_y);
        p1_next.ra  = request.radius_a;
    end

    // products
    always_comb
    begin
        logic signed [49:0] t_dx2, t_dy2, t_abx2, t_aby2;
        logic signed [51:0] t_ac2x, t_ac2y, t_ec2x, t_ec2y;
        t_dx2  = p1_reg.dx * p1_reg.dx;
        t_dy2  = p1_reg.dy * p1_reg.dy;
        t_abx2 = p1_reg.abx * p1_reg.abx;
        t_aby2 = p1_reg.aby * p1_reg.aby;
        t_ac2x = p1_reg.acx * p1_reg.acx;
        t_ac2y = p1_reg.acy * p1_reg.acy;
        t_ec2x = p1_reg.ecx * p1_reg.ecx;
        t_ec2y = p1_reg.ecy * p1_reg.ecy;

        p2_next.side.act   = p1_reg.act;
        p2_next.side.hit   = 1'b0;
        p2_next.side.nz    = 1'b0;
        p2_next.side.sum   = p1_reg.sum;
        p2_next.side.neg_x = p1_reg.dx[24];
        p2_next.side.neg_y = p1_reg.dy[24];
        p2_next.side.mag_x = p1_reg.dx[24] ? 24'(-p1_reg.dx) : p1_reg.dx[23:0];
        p2_next.side.mag_y = p1_reg.dy[24] ? 24'(-p1_reg.dy) : p1_reg.dy[23:0];
        p2_next.dx2   = t_dx2[47:0];
        p2_next.dy2   = t_dy2[47:0];
        p2_next.sum2  = p1_reg.sum * p1_reg.sum;
        p2_next.dot_x = p1_reg.abx * p1_reg.acx;
        p2_next.dot_y = p1_reg.aby * p1_reg.acy;
        p2_next.abx2  = t_abx2[47:0];
        p2_next.aby2  = t_aby2[47:0];
        p2_next.cr_a  = p1_reg.abx * p1_reg.acy;
        p2_next.cr_b  = p1_reg.aby * p1_reg.acx;
        p2_next.ac2x  = t_ac2x[49:0];
        p2_next.ac2y  = t_ac2y[49:0];
        p2_next.ec2x  = t_ec2x[49:0];
        p2_next.ec2y  = t_ec2y[49:0];
        p2_next.r2    = p1_reg.ra * p1_reg.ra;
    end

    // sums
    always_comb
    begin
        p3_next.side = p2_reg.side;
        p3_next.s    = {2'b00, p2_reg.dx2} + {2'b00, p2_reg.dy2};
        p3_next.sum2 = p2_reg.sum2;
        p3_next.dot  = {p2_reg.dot_x[50], p2_reg.dot_x} + {p2_reg.dot_y[50], p2_reg.dot_y};
        p3_next.l2   = {2'b00, p2_reg.abx2} + {2'b00, p2_reg.aby2};
        p3_next.cr   = {p2_reg.cr_a[50], p2_reg.cr_a} - {p2_reg.cr_b[50], p2_reg.cr_b};
        p3_next.da   = {1'b0, p2_reg.ac2x} + {1'b0, p2_reg.ac2y};
        p3_next.de   = {1'b0, p2_reg.ec2x} + {1'b0, p2_reg.ec2y};
        p3_next.r2   = p2_reg.r2;
    end

    cct_sqrt u_sqrt (
        .clk      (clk),
        .radicand ({p3_reg.s, 14'd0}),
        .root     (root)
    );

    // circle hit, segment region and end point tests
    always_comb
    begin
        p4_next.side     = p3_reg.side;
        p4_next.side.hit = p3_reg.s < {2'b00, p3_reg.sum2};
        p4_next.side.nz  = p3_reg.s != '0;
        p4_next.crm      = p3_reg.cr[51] ? 51'(-p3_reg.cr) : p3_reg.cr[50:0];
        p4_next.lo       = p3_reg.dot[51] || (p3_reg.dot == '0);
        p4_next.hi       = !p3_reg.dot[51] && (p3_reg.dot[50:0] >= {1'b0, p3_reg.l2});
        p4_next.hit_a    = p3_reg.da < {5'd0, p3_reg.r2};
        p4_next.hit_e    = p3_reg.de < {5'd0, p3_reg.r2};
        p4_next.r2       = p3_reg.r2;
        p4_next.l2       = p3_reg.l2;
    end

    // partial products of cross^2 and r^2 * |ab|^2
    always_comb
    begin
        p5_next.side  = p4_reg.side;
        p5_next.lo    = p4_reg.lo;
        p5_next.hi    = p4_reg.hi;
        p5_next.hit_a = p4_reg.hit_a;
        p5_next.hit_e = p4_reg.hit_e;
        p5_next.phh   = p4_reg.crm[50:26] * p4_reg.crm[50:26];
        p5_next.phl   = p4_reg.crm[50:26] * p4_reg.crm[25:0];
        p5_next.pll   = p4_reg.crm[25:0] * p4_reg.crm[25:0];
        p5_next.q11   = p4_reg.r2[45:23] * p4_reg.l2[49:26];
        p5_next.q10   = p4_reg.r2[45:23] * p4_reg.l2[25:0];
        p5_next.q01   = p4_reg.r2[22:0] * p4_reg.l2[49:26];
        p5_next.q00   = p4_reg.r2[22:0] * p4_reg.l2[25:0];
    end

    always_comb
    begin
        p6_next.side  = p5_reg.side;
        p6_next.lo    = p5_reg.lo;
        p6_next.hi    = p5_reg.hi;
        p6_next.hit_a = p5_reg.hit_a;
        p6_next.hit_e = p5_reg.hit_e;
        p6_next.cr_sq = {p5_reg.phh, 52'd0} + {24'd0, p5_reg.phl, 27'd0}
                      + {50'd0, p5_reg.pll};
        p6_next.rl    = {6'd0, p5_reg.q11, 49'd0} + {30'd0, p5_reg.q10, 23'd0}
                      + {29'd0, p5_reg.q01, 26'd0} + {53'd0, p5_reg.q00};
    end

    // final hit select
    always_comb
    begin
        logic seg_hit;
        priority if (p6_reg.lo)
            seg_hit = p6_reg.hit_a;
        else if (p6_reg.hi)
            seg_hit = p6_reg.hit_e;
        else
            seg_hit = p6_reg.cr_sq < p6_reg.rl;
        p7_next     = p6_reg.side;
        p7_next.hit = (p6_reg.side.act == ACT_SEGMENT) ? seg_hit : p6_reg.side.hit;
    end

    // depth and normal numerators once the root is out
    always_comb
    begin
        side_t       sd;
        logic        circ;
        logic [24:0] dep;
        sd   = side_reg[SIDE_DLY-1];
        circ = sd.hit && (sd.act == ACT_CIRCLE);
        dep  = {1'b0, sd.sum} - root[SQRT_STEPS-1:7];
        pn_next.tail.hit    = sd.hit;
        pn_next.tail.nrm_en = circ && sd.nz;
        pn_next.tail.neg_x  = sd.neg_x;
        pn_next.tail.neg_y  = sd.neg_y;
        pn_next.tail.depth  = circ ? dep[23:0] : '0;
        pn_next.num_x = {1'b0, sd.mag_x, 21'd0} + {15'd0, root[SQRT_STEPS-1:1]};
        pn_next.num_y = {1'b0, sd.mag_y, 21'd0} + {15'd0, root[SQRT_STEPS-1:1]};
        pn_next.den   = root;
    end

    cct_div u_div_x (
        .clk (clk),
        .num (pn_reg.num_x),
        .den (pn_reg.den),
        .quo (quo_x)
    );

    cct_div u_div_y (
        .clk (clk),
        .num (pn_reg.num_y),
        .den (pn_reg.den),
        .quo (quo_y)
    );

    // clamp to one, apply sign, mask
    always_comb
    begin
        tail_t           tl;
        logic [DIV_STEPS-1:0] nx, ny;
        tl = tail_reg[DIV_STEPS-1];
        nx = (quo_x > NORM_ONE) ? NORM_ONE : quo_x;
        ny = (quo_y > NORM_ONE) ? NORM_ONE : quo_y;
        res_next.hit   = tl.hit;
        res_next.depth = tl.depth;
        if (tl.nrm_en)
        begin
            res_next.normal_x = tl.neg_x ? -{1'b0, nx} : {1'b0, nx};
            res_next.normal_y = tl.neg_y ? -{1'b0, ny} : {1'b0, ny};
        end
        else
        begin
            res_next.normal_x = '0;
            res_next.normal_y = '0;
        end
    end

    assign vld_next = {vld_reg[CCT_LATENCY-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        p3_reg <= p3_next;
        p4_reg <= p4_next;
        p5_reg <= p5_next;
        p6_reg <= p6_next;
        p7_reg <= p7_next;
        side_reg[0] <= p7_reg;
        for (int k = 1; k < SIDE_DLY; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
        pn_reg <= pn_next;
        tail_reg[0] <= pn_reg.tail;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            tail_reg[k] <= tail_reg[k-1];
        end
        res_reg <= res_next;
    end

    assign done   = vld_reg[CCT_LATENCY-1];
    assign result = res_reg;

endmodule

// ----- rtl/cct_check.sv -----
// port checker for circle_collision_test_top, attached by bind
// depends on cct_pkg and circle_collision_test_top_assert.svh
`include "circle_collision_test_top_assert.svh"

module cct_check (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input cct_pkg::cct_in_t  request,
    input logic              done,
    input cct_pkg::cct_out_t result
);
    import cct_pkg::*;

    logic res_zero;

    assign res_zero = (result.depth == '0) && (result.normal_x == '0)
                   && (result.normal_y == '0);

    // every item comes back after the fixed latency, and nothing else does
    `CCT_IMPLY(a_latency, start && !busy, ##CCT_LATENCY done)
    `CCT_IMPLY(a_no_spurious, done, $past(start && !busy, CCT_LATENCY))
    // a miss carries no depth and no normal
    `CCT_IMPLY(a_miss_zero, done && !result.hit, res_zero)
    // segment items report only the flag
    `CCT_IMPLY(a_seg_flag_only, done && $past(request.action == ACT_SEGMENT, CCT_LATENCY), res_zero)

endmodule

bind circle_collision_test_top cct_check u_cct_check (.*);

// ----- tb/sv/tb_top.sv -----
// testbench for circle_collision_test_top: directed and random pair tests
// checked one by one against an in-bench collision predictor
// depends on cct_pkg and the block's rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cct_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int TAIL     = CCT_LATENCY + 20;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    logic     done;
    cct_in_t  request = '0;
    cct_out_t result;

    cct_in_t  pending_items[$];
    cct_out_t expected_hits[$];
    int       errors = 0;
    int       idle_cycles = 0;
    int       gap_left = 0;
    int       burst_left = 0;
    bit       hold_until_empty = 1'b0;

    circle_collision_test_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .request(request), .done(done), .result(result)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] unit_comp(input longint d, input logic [63:0] q);
        logic [63:0] m;
        logic [63:0] n;
        m = (d < 0) ? -d : d;
        n = ((m << 21) + q / 2) / q;
        if (n > 16384) n = 16384;
        return (d < 0) ? -$signed(16'(n)) : 16'(n);
    endfunction

    function automatic cct_out_t predict_collision(input cct_in_t it);
        cct_out_t o;
        longint ax, ay, bx, by, dx, dy, sx, sy, ex, ey;
        longint abx, aby, acx, acy, dt, l2, cx, cy;
        logic [63:0] s, rsum, ra, r2, q;
        logic [127:0] cr, lhs, rhs;
        o = '0;
        ax = it.centre_a_x; ay = it.centre_a_y;
        bx = it.origin_b_x; by = it.origin_b_y;
        ra = it.radius_a;
        if (it.action == ACT_CIRCLE)
        begin
            dx = bx - ax; dy = by - ay;
            s = dx * dx + dy * dy;
            rsum = ra + it.radius_b;
            if (s < rsum * rsum)
            begin
                o.hit = 1'b1;
                o.depth = 24'(rsum - int_sqrt(s));
                if (s != 0)
                begin
                    q = int_sqrt(s << 14);
                    o.normal_x = unit_comp(dx, q);
                    o.normal_y = unit_comp(dy, q);
                end
            end
        end
        else
        begin
            sx = it.seg_start_x; sy = it.seg_start_y;
            ex = it.seg_end_x; ey = it.seg_end_y;
            abx = ex - sx; aby = ey - sy;
            acx = ax - (bx + sx); acy = ay - (by + sy);
            dt = abx * acx + aby * acy;
            l2 = abx * abx + aby * aby;
            r2 = ra * ra;
            if (dt <= 0)
                o.hit = (64'(acx * acx) + 64'(acy * acy)) < r2;
            else if (dt >= l2)
            begin
                cx = ax - (bx + ex); cy = ay - (by + ey);
                o.hit = (64'(cx * cx) + 64'(cy * cy)) < r2;
            end
            else
            begin
                cr = 128'(abx * acy - aby * acx);
                if (abx * acy - aby * acx < 0) cr = 128'(-(abx * acy - aby * acx));
                lhs = cr * cr;
                rhs = 128'(r2) * 128'(l2);
                o.hit = lhs < rhs;
            end
        end
        return o;
    endfunction

    function automatic logic [23:0] rnd24(input int scale);
        case (scale)
            0: return 24'($urandom);
            1: return 24'($signed(12'($urandom)));
            default: return 24'($signed(18'($urandom)));
        endcase
    endfunction

    function automatic cct_in_t random_item();
        cct_in_t it;
        int sc;
        sc = $urandom_range(0, 2);
        it.action      = 1'($urandom);
        it.centre_a_x  = rnd24(sc);
        it.centre_a_y  = rnd24(sc);
        it.origin_b_x  = rnd24(sc);
        it.origin_b_y  = rnd24(sc);
        it.radius_a    = (sc == 0) ? 23'($urandom) : 23'($urandom_range(0, 1 << (sc * 6 + 11)));
        it.radius_b    = (sc == 0) ? 23'($urandom) : 23'($urandom_range(0, 1 << (sc * 6 + 11)));
        it.seg_start_x = rnd24(sc);
        it.seg_start_y = rnd24(sc);
        it.seg_end_x   = ($urandom_range(0, 15) == 0) ? it.seg_start_x : rnd24(sc);
        it.seg_end_y   = ($urandom_range(0, 15) == 0) ? it.seg_start_y : rnd24(sc);
        return it;
    endfunction

    // driver: bursts and gaps, plus a hold until the pipe has drained
    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            expected_hits.push_back(predict_collision(request));
        end
        if (hold_until_empty && expected_hits.size() == 0 && !(start && !busy))
            hold_until_empty <= 1'b0;
        if (start && busy)
            ;
        else if (hold_until_empty || !rst_n || pending_items.size() == 0)
            start <= 1'b0;
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end
        else
        begin
            request <= pending_items.pop_front();
            start <= 1'b1;
            if (burst_left > 0)
                burst_left <= burst_left - 1;
            else
            begin
                burst_left <= $urandom_range(0, 30);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        cct_out_t exp_r;
        if (rst_n && (done || (start && !busy)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && done)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, result);
                errors++;
            end
            else
            begin
                exp_r = expected_hits.pop_front();
                if (result.hit !== exp_r.hit)
                    $display("%0t: hit expected %0d actual %0d", $time, exp_r.hit, result.hit);
                if (result.depth !== exp_r.depth)
                    $display("%0t: depth expected %0d actual %0d", $time, exp_r.depth,
                        result.depth);
                if (result.normal_x !== exp_r.normal_x)
                    $display("%0t: normal_x expected %0d actual %0d", $time, exp_r.normal_x,
                        result.normal_x);
                if (result.normal_y !== exp_r.normal_y)
                    $display("%0t: normal_y expected %0d actual %0d", $time, exp_r.normal_y,
                        result.normal_y);
                if (result !== exp_r)
                    errors++;
            end
        end
        if (idle_cycles > WATCHDOG)
        begin
            $display("[circle_collision_test_top] ERROR");
            $finish;
        end
    end

    task automatic add_item(input logic act, input int ax, input int ay, input int ra,
        input int bx, input int by, input int rb, input int sx, input int sy,
        input int ex, input int ey);
        cct_in_t it;
        it.action = act;
        it.centre_a_x = 24'(ax); it.centre_a_y = 24'(ay); it.radius_a = 23'(ra);
        it.origin_b_x = 24'(bx); it.origin_b_y = 24'(by); it.radius_b = 23'(rb);
        it.seg_start_x = 24'(sx); it.seg_start_y = 24'(sy);
        it.seg_end_x = 24'(ex); it.seg_end_y = 24'(ey);
        pending_items.push_back(it);
    endtask

    initial
    begin
        int n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // directed items: extremes, coincident centres, degenerate segment
        add_item(ACT_CIRCLE, 0, 0, 256, 0, 0, 256, 0, 0, 0, 0);
        add_item(ACT_CIRCLE, 0, 0, 256, 256, 0, 256, 0, 0, 0, 0);
        add_item(ACT_CIRCLE, 0, 0, 256, 512, 0, 256, 0, 0, 0, 0);
        add_item(ACT_CIRCLE, 0, 0, 300, -100, 100, 0, 0, 0, 0, 0);
        add_item(ACT_CIRCLE, -8388608, -8388608, 8388607, 8388607, 8388607, 8388607, 0, 0, 0, 0);
        add_item(ACT_CIRCLE, 8388607, -8388608, 8388607, -8388608, 8388607, 8388607,
            -1, -1, -1, -1);
        add_item(ACT_CIRCLE, 5, 5, 0, 5, 5, 0, 0, 0, 0, 0);
        add_item(ACT_CIRCLE, 1, 1, 1, 0, 0, 1, 0, 0, 0, 0);
        add_item(ACT_CIRCLE, 0, 0, 8388607, 0, 7, 0, 0, 0, 0, 0);
        add_item(ACT_SEGMENT, 0, 100, 200, 0, 0, 0, -500, 0, 500, 0);
        add_item(ACT_SEGMENT, 0, 300, 200, 0, 0, 0, -500, 0, 500, 0);
        add_item(ACT_SEGMENT, -600, 0, 200, 0, 0, 0, -500, 0, 500, 0);
        add_item(ACT_SEGMENT, 700, 0, 100, 0, 0, 0, -500, 0, 500, 0);
        add_item(ACT_SEGMENT, 10, 10, 20, 0, 0, 0, 5, 5, 5, 5);
        add_item(ACT_SEGMENT, 10, 10, 1, 0, 0, 0, 10, 10, 10, 10);
        add_item(ACT_SEGMENT, -8388608, -8388608, 8388607, 8388607, 8388607, 8388607,
            -8388608, -8388608, 8388607, 8388607);
        add_item(ACT_SEGMENT, 8388607, 8388607, 8388607, -8388608, -8388608, 0,
            8388607, -8388608, -8388608, 8388607);
        add_item(ACT_SEGMENT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(ACT_SEGMENT, 50, 50, 1000, 0, 0, 0, 0, 0, 100, 100);
        hold_until_empty <= 1'b1;
        @(posedge clk);
        while (pending_items.size() != 0) @(posedge clk);
        // drain once before the random part
        hold_until_empty <= 1'b1;
        for (n = 0; n < 1950; n++)
            pending_items.push_back(random_item());
        while (pending_items.size() != 0 || start) @(posedge clk);
        while (expected_hits.size() != 0) @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (errors == 0 && expected_hits.size() == 0)
            $display("[circle_collision_test_top] OK");
        else
            $display("[circle_collision_test_top] ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cct_pkg.sv
rtl/cct_sqrt.sv
rtl/cct_div.sv
rtl/circle_collision_test_top.sv
rtl/cct_check.sv
tb/sv/tb_top.sv
